// ----- rtl/core/sctm_pkg.sv -----
// shared types and constants for the sparse csc transpose mat-vec unit
// no dependencies; imported by every module of the unit

package sctm_pkg;

    // vector store depth default
    localparam int VECTOR_DEPTH_DEF = 1024;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ACC   = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         element_index;
        logic signed [31:0] vector_value;
        logic signed [31:0] matrix_value;
    } t_in;

    // output word
    typedef struct packed {
        logic signed [63:0] column_sum;
        logic               saturated;
    } t_out;

    // classified command kinds
    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_ACC   = 2'd1,
        K_CLOSE = 2'd2
    } t_kind;

    // command passed from front to back
    typedef struct packed {
        t_kind              kind;
        logic [9:0]         index;
        logic signed [31:0] operand;
    } t_cmd;

endpackage

// ----- rtl/core/sctm_front.sv -----
// front end: accepts input words, drops ignored ones, forms commands
// depends on sctm_pkg

module sctm_front import sctm_pkg::*; #(
    parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_cmd
);

    logic        r_f_valid;
    t_cmd        r_f_cmd;
    logic        accept;
    logic        keep;
    t_cmd        cmd;
    logic [31:0] idx_wide;
    logic        in_range;

    assign o_in_stall = r_f_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_f_valid && !i_q_full;
    assign o_cmd      = r_f_cmd;

    assign idx_wide = 32'(i_in_data.element_index);
    assign in_range = idx_wide < 32'(VECTOR_DEPTH);

    // classify: out-of-range loads and nonzeros and the reserved code vanish here
    always_comb begin
        cmd.index   = i_in_data.element_index;
        cmd.operand = i_in_data.vector_value;
        cmd.kind    = K_CLOSE;
        keep        = 1'b0;
        case (i_in_data.opcode)
            OP_LOAD: begin
                cmd.kind    = K_LOAD;
                cmd.operand = i_in_data.vector_value;
                keep        = in_range;
            end
            OP_ACC: begin
                cmd.kind    = K_ACC;
                cmd.operand = i_in_data.matrix_value;
                keep        = in_range;
            end
            OP_CLOSE: begin
                cmd.kind = K_CLOSE;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (accept) begin
            r_f_valid <= keep;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_cmd <= cmd;
        end
    end

endmodule

// ----- rtl/core/sctm_queue.sv -----
// short command fifo between front and back
// depends on sctm_pkg

module sctm_queue import sctm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slot[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

// ----- rtl/core/sctm_back.sv -----
// back end: vector store, multiply, saturating accumulate, output register
// depends on sctm_pkg

module sctm_back import sctm_pkg::*; #(
    parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    logic signed [31:0] r_vec_mem [VECTOR_DEPTH];

    logic               en;
    logic [31:0]        idx_wide;
    logic [AW-1:0]      addr;

    // stage 1: store read data and operand
    logic               r_s1_valid;
    t_kind              r_s1_kind;
    logic signed [31:0] r_s1_operand;
    logic signed [31:0] r_rdata;
    // stage 2: product
    logic               r_s2_valid;
    t_kind              r_s2_kind;
    logic signed [63:0] r_prod;
    logic signed [63:0] prod;
    // accumulator
    logic signed [63:0] r_acc;
    logic               r_clip;
    logic signed [63:0] sum;
    logic               ovf;
    logic               s2_acc;
    logic               s2_close;
    // output register
    logic               r_out_valid;
    t_out               r_out;

    // whole back pipeline moves unless a finished sum waits on a stalled sink
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && !i_q_empty;

    assign idx_wide = 32'(i_head.index);
    assign addr     = idx_wide[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == K_LOAD) begin
            r_vec_mem[addr] <= i_head.operand;
        end
        if (en) begin
            r_rdata <= r_vec_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= o_pop && i_head.kind != K_LOAD;
            r_s2_valid <= r_s1_valid;
        end
    end

    assign prod = 64'(r_rdata) * 64'(r_s1_operand);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind    <= i_head.kind;
            r_s1_operand <= i_head.operand;
            r_s2_kind    <= r_s1_kind;
            r_prod       <= prod;
        end
    end

    assign sum      = r_acc + r_prod;
    assign ovf      = (r_acc[63] == r_prod[63]) && (sum[63] != r_acc[63]);
    assign s2_acc   = en && r_s2_valid && r_s2_kind == K_ACC;
    assign s2_close = en && r_s2_valid && r_s2_kind == K_CLOSE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (s2_close) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (s2_acc) begin
            if (ovf) begin
                r_acc  <= r_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                r_clip <= 1'b1;
            end else begin
                r_acc <= sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_close) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_close) begin
            r_out.column_sum <= r_acc;
            r_out.saturated  <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_close |=> (r_acc == '0) && !r_clip && r_out_valid)
        else $error("close did not clear accumulator or post result");

    a_clip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clip && !s2_close) |=> r_clip)
        else $error("clip flag dropped before close");

endmodule

// ----- rtl/core/sparse_csc_transpose_matvec_unit.sv -----
// top level of the sparse csc transpose mat-vec unit (y = A^T * x)
// depends on sctm_pkg, sctm_front, sctm_queue, sctm_back
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall    | t_in: opcode, index, vector, matrix
//  out     | output    | o_out_valid / i_out_stall  | t_out: column_sum, saturated
//
// one input word per cycle sustained while the output is not stalled; the single
//   32x32 multiplier and the vector store read port each serve one word per cycle
// a close word passes the front register, a queue slot, the store read, the multiply
//   and the accumulate into the output register on its way to its result, and waits
//   longer while older words wait in the queue
// reset (i_rst_n low, synchronous) clears control, accumulator and clip flag;
//   the vector store is not cleared and must be loaded before use
// a stalled output freezes the back pipeline; the front keeps accepting until
//   the four-entry command queue and its own register fill, then raises o_in_stall

module sparse_csc_transpose_matvec_unit import sctm_pkg::*; #(
    parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;
    // queue to back
    logic pop;
    logic q_empty;
    t_cmd head;

    // classifies words; loads and nonzeros outside the store and the
    // reserved opcode are dropped here
    sctm_front #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // decouples front from back so each stalls on its own
    sctm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // in-order execution keeps store writes ahead of later reads and
    // accumulates ahead of the close that sums them
    sctm_back #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
